// File: design/rtip_pkg.sv
package rtip_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_RADIX       = 2'd0;
   localparam logic [1:0] CSR_FOLD_CASE   = 2'd1;
   localparam logic [1:0] CSR_RESULT_MODE = 2'd2;

   // Result range selection.
   localparam logic [1:0] MODE_UNSIGNED64 = 2'd0;
   localparam logic [1:0] MODE_SIGNED64   = 2'd1;
   localparam logic [1:0] MODE_SIGNED32   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [4:0] RADIX_RESET       = 5'd10;
   localparam logic       FOLD_CASE_RESET   = 1'b1;
   localparam logic [1:0] RESULT_MODE_RESET = MODE_SIGNED64;

   localparam logic [4:0] RADIX_MIN = 5'd2;
   localparam logic [4:0] RADIX_MAX = 5'd16;

   // Character codes.
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;

   // Range limits of the signed modes.
   localparam logic [63:0] POS_LIMIT_64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] POS_LIMIT_32 = 64'h0000_0000_7FFF_FFFF;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_NO_DIGIT = 3'd1,
      STATUS_DUP_SIGN = 3'd2,
      STATUS_BAD_CHAR = 3'd3,
      STATUS_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PHASE_START  = 2'd0,
      PHASE_SIGNED = 2'd1,
      PHASE_DIGITS = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_word_type;

   typedef struct packed {
      logic [63:0] value;
      logic [2:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic [4:0] radix;
      logic       fold_case;
      logic [1:0] result_mode;
   } cfg_type;

   typedef struct packed {
      logic [63:0] accumulator;
      logic        negative;
      phase_type   phase;
      status_type  error_code;
   } field_state_type;

   localparam field_state_type FIELD_CLEAR = '{
      accumulator: 64'd0,
      negative:    1'b0,
      phase:       PHASE_START,
      error_code:  STATUS_OK
   };

endpackage

// File: design/rtip_csr.sv
module rtip_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_data,
   output rtip_pkg::cfg_type cfg
);

   rtip_pkg::cfg_type cfg_ff;
   rtip_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            rtip_pkg::CSR_RADIX:       cfg_in.radix       = csr_data;
            rtip_pkg::CSR_FOLD_CASE:   cfg_in.fold_case   = csr_data[0];
            rtip_pkg::CSR_RESULT_MODE: cfg_in.result_mode = csr_data[1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix       <= rtip_pkg::RADIX_RESET;
         cfg_ff.fold_case   <= rtip_pkg::FOLD_CASE_RESET;
         cfg_ff.result_mode <= rtip_pkg::RESULT_MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/rtip_step.sv
module rtip_step (
   input  rtip_pkg::cfg_type         cfg,
   input  rtip_pkg::field_state_type state,
   input  rtip_pkg::req_word_type    word,
   output rtip_pkg::field_state_type state_next,
   output rtip_pkg::rsp_word_type    result
);

   logic [4:0]  base;
   logic        is_signed;
   logic        digit_ok;
   logic [3:0]  digit;
   logic [68:0] product;
   logic        take_digit;
   logic [63:0] pos_limit;
   logic [63:0] neg_limit;
   logic [7:0]  c;
   rtip_pkg::field_state_type upd;
   rtip_pkg::status_type      final_status;

   assign c = word.char_code;

   always_comb begin
      if (cfg.radix < rtip_pkg::RADIX_MIN) begin
         base = rtip_pkg::RADIX_MIN;
      end else if (cfg.radix > rtip_pkg::RADIX_MAX) begin
         base = rtip_pkg::RADIX_MAX;
      end else begin
         base = cfg.radix;
      end
   end

   assign is_signed = (cfg.result_mode != rtip_pkg::MODE_UNSIGNED64);

   // Digit decode; letters A to F give ten to fifteen.
   always_comb begin
      digit_ok = 1'b0;
      digit    = 4'd0;
      if (c >= rtip_pkg::CHAR_ZERO && c <= rtip_pkg::CHAR_NINE) begin
         digit_ok = 1'b1;
         digit    = 4'(c - rtip_pkg::CHAR_ZERO);
      end else if (c >= rtip_pkg::CHAR_UPPER_A && c <= rtip_pkg::CHAR_UPPER_F) begin
         digit_ok = 1'b1;
         digit    = 4'(c - rtip_pkg::CHAR_UPPER_A + 8'd10);
      end else if (cfg.fold_case && c >= rtip_pkg::CHAR_LOWER_A
                   && c <= rtip_pkg::CHAR_LOWER_F) begin
         digit_ok = 1'b1;
         digit    = 4'(c - rtip_pkg::CHAR_LOWER_A + 8'd10);
      end
      if ({1'b0, digit} >= base) begin
         digit_ok = 1'b0;
      end
   end

   // Any bit above the low 64 means the magnitude has left the unsigned range.
   assign product = 69'(state.accumulator) * 69'(base) + 69'(digit);

   always_comb begin
      upd        = state;
      take_digit = 1'b0;
      if (state.error_code == rtip_pkg::STATUS_OK) begin
         take_digit = 1'b1;
         case (state.phase)
            rtip_pkg::PHASE_START: begin
               if (c == rtip_pkg::CHAR_PLUS || (is_signed && c == rtip_pkg::CHAR_MINUS)) begin
                  take_digit   = 1'b0;
                  upd.negative = (c == rtip_pkg::CHAR_MINUS);
                  upd.phase    = rtip_pkg::PHASE_SIGNED;
                  if (word.last_char) begin
                     upd.error_code = rtip_pkg::STATUS_NO_DIGIT;
                  end
               end
            end
            rtip_pkg::PHASE_SIGNED: begin
               if (is_signed && c == rtip_pkg::CHAR_PLUS) begin
                  take_digit     = 1'b0;
                  upd.error_code = rtip_pkg::STATUS_DUP_SIGN;
               end
            end
            default: begin
            end
         endcase
         if (take_digit) begin
            upd.phase = rtip_pkg::PHASE_DIGITS;
            if (!digit_ok) begin
               upd.error_code = rtip_pkg::STATUS_BAD_CHAR;
            end else if (product[68:64] != 5'd0) begin
               upd.error_code = rtip_pkg::STATUS_OVERFLOW;
            end else begin
               upd.accumulator = product[63:0];
            end
         end
      end
   end

   assign pos_limit = (cfg.result_mode == rtip_pkg::MODE_SIGNED32) ?
                      rtip_pkg::POS_LIMIT_32 : rtip_pkg::POS_LIMIT_64;
   assign neg_limit = pos_limit + 64'd1;

   always_comb begin
      final_status = upd.error_code;
      result.value = 64'd0;
      if (upd.error_code == rtip_pkg::STATUS_OK) begin
         if (!is_signed) begin
            result.value = upd.accumulator;
         end else if (upd.negative) begin
            if (upd.accumulator > neg_limit) begin
               final_status = rtip_pkg::STATUS_OVERFLOW;
            end else begin
               result.value = 64'd0 - upd.accumulator;
            end
         end else begin
            if (upd.accumulator > pos_limit) begin
               final_status = rtip_pkg::STATUS_OVERFLOW;
            end else begin
               result.value = upd.accumulator;
            end
         end
      end
      result.status = 3'(final_status);
   end

   // The field ends with its last character and the next one starts afresh.
   assign state_next = word.last_char ? rtip_pkg::FIELD_CLEAR : upd;

endmodule

// File: design/radix_integer_text_parser_core.sv
// Streaming parser that turns the text of one number field into an integer.
// The req channel carries one character per word, with last_char marking the
// final character of the field. The rsp channel carries one word per field,
// the parsed value and a status, issued once the last character is folded in.
// Both channels move a word at a rising edge with valid high and stall low.
// The csr channel writes radix, fold_case and result_mode (indexes 0 to 2) at
// an edge with csr_valid and csr_ready high; csr_ready is always high, and
// registers are meant to be written only while no field is in flight.
// A character goes into an input register on acceptance and is folded into
// the field state from there, at the edge where the word of a finished field
// is loaded into the rsp register; rsp_valid rises with that load. One
// character is taken per cycle while req_stall is low; the single
// multiply-add of the accumulator by the radix sets that.
// Characters that give no result keep flowing while the rsp word is stalled;
// a last character waits in the input register until the rsp register is
// free, and req_stall is raised behind it.
// Reset clears the field state, empties both registers and loads the
// configuration defaults: radix ten, case folding on, signed 64-bit range.
module radix_integer_text_parser_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rtip_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rtip_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [4:0]             csr_data
);

   rtip_pkg::cfg_type         cfg;
   rtip_pkg::field_state_type state_ff;
   rtip_pkg::field_state_type state_in;
   rtip_pkg::rsp_word_type    result;

   logic                   in_valid_ff;
   rtip_pkg::req_word_type in_word_ff;
   logic                   rsp_valid_ff;
   rtip_pkg::rsp_word_type rsp_word_ff;
   logic                   advance;
   logic                   rsp_free;

   // The configuration never pushes back.
   assign csr_ready = 1'b1;

   rtip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rtip_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .word       (in_word_ff),
      .state_next (state_in),
      .result     (result)
   );

   // The result register can take a new word when it is empty or being read.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // A character that closes a field needs room in the result register;
   // any other character moves on at once.
   assign advance   = in_valid_ff && (!in_word_ff.last_char || rsp_free);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_word_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtip_pkg::FIELD_CLEAR;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_word_ff.last_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_word_ff.last_char) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
